// ===== hdl/dcfr_pkg.sv =====
// Shared types, codes and helpers of the daisy-chain frame relay.
`timescale 1ns / 1ps

package dcfr_pkg;

   localparam int FRAME_MAX_DEFAULT = 32;

   localparam logic [7:0] TERM_BYTE       = 8'hff;
   localparam logic [7:0] SUM_SUBSTITUTE  = 8'hfe;
   localparam logic [7:0] PING_BYTE       = 8'h05;
   localparam logic [7:0] WARN_LEAD       = 8'd10;
   localparam logic [7:0] TIMEOUT_RESET   = 8'd100;

   localparam logic [7:0] CMD_VOLT  = 8'd1;
   localparam logic [7:0] CMD_SHUNT = 8'd2;
   localparam logic [7:0] CMD_TEMP  = 8'd3;
   localparam logic [7:0] CMD_HOP   = 8'd4;
   localparam logic [7:0] CMD_PING  = 8'd5;

   typedef enum logic [2:0] {
      SEL_CMD,
      SEL_SECOND,
      SEL_MEM,
      SEL_SUM,
      SEL_TERM,
      SEL_PING
   } sel_type;

   typedef struct packed {
      logic    capture;
      logic    step;
      logic    fetch;
      logic    fire;
      sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic warn;
      logic relay;
      logic has_second;
      logic cmd_hop;
      logic cmd_ping;
      logic loop_done;
   } dp_status_type;

   function automatic logic [7:0] fix_sum(input logic [7:0] s);
      fix_sum = (s == 8'h00 || s == TERM_BYTE) ? SUM_SUBSTITUTE : s;
   endfunction

endpackage

// ===== hdl/dcfr_datapath.sv =====
// Datapath of the frame relay: frame store, counters, checksum and output selection.
`timescale 1ns / 1ps

module dcfr_datapath #(
   parameter int FRAME_MAX = dcfr_pkg::FRAME_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [7:0]             csr_write_data,
   input  logic                   req_type,
   input  logic [7:0]             req_rx_byte,
   input  logic [7:0]             req_volt_value,
   input  logic [7:0]             req_temp_value,
   input  dcfr_pkg::dp_cmd_type   cmd,
   output dcfr_pkg::dp_status_type status,
   output logic [7:0]             rsp_tx_byte,
   output logic                   rsp_last_byte,
   output logic                   rsp_shunt_on
);

   localparam int AW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
   localparam int CW = $clog2(FRAME_MAX + 1);

   logic [7:0] mem [FRAME_MAX];

   logic          type_ff;
   logic [7:0]    byte_ff;
   logic [7:0]    volt_ff;
   logic [7:0]    temp_ff;
   logic [7:0]    rd_ff;

   logic [7:0]    timeout_ff, timeout_in;
   logic [7:0]    tick_ff, tick_in;
   logic          in_frame_ff, in_frame_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    sum_ff, sum_in;
   logic          shunt_ff, shunt_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    second_ff, second_in;
   logic [7:0]    last_ff, last_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [CW-1:0] k_ff, k_in;
   logic [7:0]    crc_ff, crc_in;

   logic [7:0]    tick_next;
   logic          warn_hit, tmo_hit, is_byte, start, abort_idle, data_byte;
   logic          overflow, store, term, frame_ok, end_rx, relay;
   logic [7:0]    check_byte, ref_sum, second_byte;

   always_comb begin
      tick_next  = tick_ff + 8'd1;
      warn_hit   = type_ff && (tick_next == timeout_ff - dcfr_pkg::WARN_LEAD);
      tmo_hit    = type_ff && (tick_next == timeout_ff);
      is_byte    = !type_ff && (byte_ff != 8'h00);
      start      = is_byte && !in_frame_ff && (byte_ff >= dcfr_pkg::CMD_VOLT)
                   && (byte_ff <= dcfr_pkg::CMD_PING);
      abort_idle = is_byte && !in_frame_ff && !start;
      data_byte  = is_byte && in_frame_ff && (byte_ff != dcfr_pkg::TERM_BYTE);
      overflow   = data_byte && (count_ff >= CW'(FRAME_MAX));
      store      = data_byte && !overflow;
      term       = is_byte && in_frame_ff && (byte_ff == dcfr_pkg::TERM_BYTE);
      check_byte = (count_ff == CW'(1)) ? cmd_ff : last_ff;
      ref_sum    = dcfr_pkg::fix_sum(sum_ff - check_byte);
      frame_ok   = term && (ref_sum == check_byte);
      end_rx     = abort_idle || overflow || term || tmo_hit;
      relay      = frame_ok || tmo_hit;
   end

   always_comb begin
      timeout_in  = timeout_ff;
      tick_in     = tick_ff;
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      shunt_in    = shunt_ff;
      cmd_in      = cmd_ff;
      second_in   = second_ff;
      last_in     = last_ff;
      lim_in      = lim_ff;
      k_in        = k_ff;
      crc_in      = crc_ff;

      if (csr_write_en) begin
         timeout_in = csr_write_data;
      end

      if (cmd.step) begin
         crc_in = 8'h00;
         if (type_ff) begin
            tick_in = tmo_hit ? 8'h00 : tick_next;
            if (tmo_hit) begin
               cmd_in    = dcfr_pkg::CMD_HOP;
               second_in = 8'h00;
            end
         end else if (is_byte) begin
            tick_in = 8'h00;
         end
         if (start) begin
            cmd_in      = byte_ff;
            count_in    = CW'(1);
            sum_in      = byte_ff;
            in_frame_in = 1'b1;
         end
         if (store) begin
            count_in = count_ff + CW'(1);
            sum_in   = sum_ff + byte_ff;
            last_in  = byte_ff;
            if (count_ff == CW'(1)) begin
               second_in = byte_ff;
            end
         end
         if (frame_ok) begin
            lim_in = count_ff - CW'(1);
         end
         if (relay) begin
            k_in = (cmd_ff == dcfr_pkg::CMD_SHUNT) ? CW'(2) : CW'(1);
         end
         if (frame_ok && cmd_ff == dcfr_pkg::CMD_SHUNT && count_ff >= CW'(3)) begin
            shunt_in = (second_ff == 8'h01);
         end
         if (end_rx) begin
            in_frame_in = 1'b0;
            count_in    = '0;
            sum_in      = 8'h00;
            if (tmo_hit || cmd_ff == dcfr_pkg::CMD_HOP) begin
               shunt_in = 1'b0;
            end
         end
      end

      if (cmd.fire) begin
         if (cmd.sel == dcfr_pkg::SEL_CMD || cmd.sel == dcfr_pkg::SEL_SECOND
             || cmd.sel == dcfr_pkg::SEL_MEM) begin
            crc_in = crc_ff + rsp_tx_byte;
         end
         if (cmd.sel == dcfr_pkg::SEL_MEM) begin
            k_in = k_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= dcfr_pkg::TIMEOUT_RESET;
         tick_ff     <= 8'h00;
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         sum_ff      <= 8'h00;
         shunt_ff    <= 1'b0;
         cmd_ff      <= 8'h00;
      end else begin
         timeout_ff  <= timeout_in;
         tick_ff     <= tick_in;
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         shunt_ff    <= shunt_in;
         cmd_ff      <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      second_ff <= second_in;
      last_ff   <= last_in;
      lim_ff    <= lim_in;
      k_ff      <= k_in;
      crc_ff    <= crc_in;
      if (cmd.capture) begin
         type_ff <= req_type;
         byte_ff <= req_rx_byte;
         volt_ff <= req_volt_value;
         temp_ff <= req_temp_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && store) begin
         mem[count_ff[AW-1:0]] <= byte_ff;
      end
      if (cmd.fetch) begin
         rd_ff <= mem[k_ff[AW-1:0]];
      end
   end

   always_comb begin
      case (cmd_ff)
         dcfr_pkg::CMD_VOLT: second_byte = volt_ff;
         dcfr_pkg::CMD_TEMP: second_byte = temp_ff;
         dcfr_pkg::CMD_HOP:  second_byte = second_ff + 8'd1;
         default:            second_byte = dcfr_pkg::PING_BYTE;
      endcase
   end

   always_comb begin
      unique case (cmd.sel)
         dcfr_pkg::SEL_CMD:    rsp_tx_byte = cmd_ff;
         dcfr_pkg::SEL_SECOND: rsp_tx_byte = second_byte;
         dcfr_pkg::SEL_MEM:    rsp_tx_byte = rd_ff;
         dcfr_pkg::SEL_SUM:    rsp_tx_byte = dcfr_pkg::fix_sum(crc_ff);
         dcfr_pkg::SEL_TERM:   rsp_tx_byte = dcfr_pkg::TERM_BYTE;
         dcfr_pkg::SEL_PING:   rsp_tx_byte = dcfr_pkg::PING_BYTE;
         default:              rsp_tx_byte = dcfr_pkg::TERM_BYTE;
      endcase
   end

   assign rsp_last_byte = (cmd.sel == dcfr_pkg::SEL_TERM);
   assign rsp_shunt_on  = shunt_ff;

   assign status.warn       = warn_hit;
   assign status.relay      = relay;
   assign status.has_second = (cmd_ff != dcfr_pkg::CMD_SHUNT);
   assign status.cmd_hop    = (cmd_ff == dcfr_pkg::CMD_HOP);
   assign status.cmd_ping   = (cmd_ff == dcfr_pkg::CMD_PING);
   assign status.loop_done  = (k_ff >= lim_ff);

endmodule

// ===== hdl/dcfr_ctrl.sv =====
// Controller of the frame relay: sequences each step and the bytes it sends.
`timescale 1ns / 1ps

module dcfr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dcfr_pkg::dp_status_type status,
   output dcfr_pkg::dp_cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_DECIDE = 10'b00_0000_0010,
      ST_CMD    = 10'b00_0000_0100,
      ST_SECOND = 10'b00_0000_1000,
      ST_LOOP   = 10'b00_0001_0000,
      ST_DATA   = 10'b00_0010_0000,
      ST_SUM    = 10'b00_0100_0000,
      ST_TERM   = 10'b00_1000_0000,
      ST_WARN1  = 10'b01_0000_0000,
      ST_WARN2  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.step    = 1'b0;
      cmd.fetch   = 1'b0;
      cmd.fire    = 1'b0;
      cmd.sel     = dcfr_pkg::SEL_CMD;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.step = 1'b1;
            if (status.warn) begin
               state_in = ST_WARN1;
            end else if (status.relay) begin
               state_in = ST_CMD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CMD: begin
            rsp_valid = 1'b1;
            cmd.sel   = dcfr_pkg::SEL_CMD;
            cmd.fire  = rsp_ready;
            if (rsp_ready) begin
               state_in = status.has_second ? ST_SECOND : ST_LOOP;
            end
         end
         ST_SECOND: begin
            rsp_valid = 1'b1;
            cmd.sel   = dcfr_pkg::SEL_SECOND;
            cmd.fire  = rsp_ready;
            if (rsp_ready) begin
               if (status.cmd_hop) begin
                  state_in = ST_SUM;
               end else if (status.cmd_ping) begin
                  state_in = ST_TERM;
               end else begin
                  state_in = ST_LOOP;
               end
            end
         end
         ST_LOOP: begin
            if (status.loop_done) begin
               state_in = ST_SUM;
            end else begin
               cmd.fetch = 1'b1;
               state_in  = ST_DATA;
            end
         end
         ST_DATA: begin
            rsp_valid = 1'b1;
            cmd.sel   = dcfr_pkg::SEL_MEM;
            cmd.fire  = rsp_ready;
            if (rsp_ready) begin
               state_in = ST_LOOP;
            end
         end
         ST_SUM: begin
            rsp_valid = 1'b1;
            cmd.sel   = dcfr_pkg::SEL_SUM;
            cmd.fire  = rsp_ready;
            if (rsp_ready) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            rsp_valid = 1'b1;
            cmd.sel   = dcfr_pkg::SEL_TERM;
            cmd.fire  = rsp_ready;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_WARN1: begin
            rsp_valid = 1'b1;
            cmd.sel   = dcfr_pkg::SEL_PING;
            cmd.fire  = rsp_ready;
            if (rsp_ready) begin
               state_in = ST_WARN2;
            end
         end
         ST_WARN2: begin
            rsp_valid = 1'b1;
            cmd.sel   = dcfr_pkg::SEL_PING;
            cmd.fire  = rsp_ready;
            if (rsp_ready) begin
               state_in = ST_TERM;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/daisy_chain_frame_relay.sv =====
// Top level of the daisy-chain frame relay: controller and datapath.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid/req_ready    req_type, req_rx_byte, req_volt_value,
//                                              req_temp_value
//  rsp_      out        rsp_valid/rsp_ready    rsp_tx_byte, rsp_last_byte, rsp_shunt_on
//  csr_      in         csr_write_en           csr_write_data (timeout in ticks)
//
//  One transaction is taken, then stepped in the following cycle; a step that sends
//  nothing goes straight back to idle. Each byte replayed from the frame store is
//  first fetched into a registered read (ST_LOOP) and then sent (ST_DATA). Each sent
//  byte waits while rsp_ready is low. The store is not cleared at reset.

module daisy_chain_frame_relay #(
   parameter int FRAME_MAX = dcfr_pkg::FRAME_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_volt_value,
   input  logic [7:0] req_temp_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last_byte,
   output logic       rsp_shunt_on
);

   dcfr_pkg::dp_cmd_type    cmd;
   dcfr_pkg::dp_status_type status;

   dcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dcfr_datapath #(
      .FRAME_MAX (FRAME_MAX)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_type       (req_type),
      .req_rx_byte    (req_rx_byte),
      .req_volt_value (req_volt_value),
      .req_temp_value (req_temp_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_shunt_on   (rsp_shunt_on)
   );

endmodule
